>>> hdl/pci_config_space_access_top_assert.svh
// assertion macros for the configuration space access block
`ifndef PCI_CONFIG_SPACE_ACCESS_TOP_ASSERT_SVH
`define PCI_CONFIG_SPACE_ACCESS_TOP_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define PCSA_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("pcsa assertion failed");

// next-cycle implication, checked while out of reset
`define PCSA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("pcsa assertion failed");

`endif

>>> hdl/pcsa_pkg.sv
// shared types, constants and tables of the configuration space access block
`default_nettype none
package pcsa_pkg;

  localparam int SPACE_BYTES = 256;
  localparam int BANKS       = 4;
  localparam int BANK_ROWS   = SPACE_BYTES / BANKS;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;
  localparam logic [7:0]  MAP_OFFSET = 8'h64;

  typedef enum logic [1:0] {
    CMD_DIRECT = 2'd0,
    CMD_MEM_RD = 2'd1,
    CMD_MEM_WR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] imm;
    logic [7:0]  off;
    logic [2:0]  size;
    logic [31:0] wdata;
    logic        here;
    logic        do_map;
    logic [7:0]  map_byte;
  } cmd_t;

  // device zero reset image
  function automatic logic [7:0] dev0_init(input logic [7:0] idx);
    logic [7:0] v;
    v = 8'h00;
    case (idx)
      8'h00: v = 8'h86;
      8'h01: v = 8'h80;
      8'h02: v = 8'ha3;
      8'h03: v = 8'h04;
      8'h04: v = 8'h06;
      8'h07: v = 8'h02;
      8'h08: v = 8'h03;
      8'h0b: v = 8'h06;
      8'h51: v = 8'h01;
      8'h52: v = 8'h01;
      8'h57: v = 8'h01;
      8'h60: v = 8'h10;
      8'h61, 8'h62, 8'h63, 8'h64, 8'h65: v = 8'h20;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // read-only bits of device zero
  function automatic logic [7:0] dev0_protect(input logic [7:0] idx);
    logic [7:0] m;
    m = 8'h00;
    if (idx inside {[8'h00:8'h03], [8'h06:8'h0b]}) begin
      m = 8'hff;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

>>> hdl/pcsa_front.sv
// front end: address and byte registers, decode of data port items
`default_nettype none
module pcsa_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic          pci_enable,
  input  wire logic          req_type,
  input  wire logic [2:0]    port_offset,
  input  wire logic [2:0]    access_size,
  input  wire logic [31:0]   write_data,
  output pcsa_pkg::cmd_t     cmd
);
  import pcsa_pkg::*;

  logic [31:0] config_address;
  logic [31:0] config_address_next;
  logic [7:0]  byte_regs [BANKS];
  logic [7:0]  byte_regs_next [BANKS];

  logic [4:0]  dev;
  logic [2:0]  fn;
  logic [31:0] ones;
  logic        size_ok;
  logic        here;
  logic        map_hit;

  assign dev = config_address[15:11];
  assign fn  = config_address[10:8];
  assign size_ok = (access_size == 3'd1) || (access_size == 3'd2) || (access_size == 3'd4);
  assign here = (dev == 5'd0) && (fn == 3'd0) && pci_enable;
  assign map_hit = req_type && config_address[31] && (dev == 5'd0) &&
                   ((config_address[7:0] + {6'd0, port_offset[1:0]}) == MAP_OFFSET);

  always_comb begin
    case (access_size)
      3'd1:    ones = 32'h0000_00ff;
      3'd2:    ones = 32'h0000_ffff;
      default: ones = ALL_ONES;
    endcase
  end

  always_comb begin
    config_address_next = config_address;
    for (int b = 0; b < BANKS; b++) begin
      byte_regs_next[b] = byte_regs[b];
    end
    cmd = '0;
    cmd.kind     = CMD_DIRECT;
    cmd.off      = config_address[7:0] + {6'd0, port_offset[1:0]};
    cmd.size     = access_size;
    cmd.wdata    = write_data;
    cmd.here     = here;
    cmd.do_map   = map_hit;
    case (access_size)
      3'd1:    cmd.map_byte = write_data[7:0];
      3'd2:    cmd.map_byte = write_data[15:8];
      default: cmd.map_byte = write_data[31:24];
    endcase

    if (!port_offset[2]) begin
      if (access_size == 3'd4 && port_offset == 3'd0) begin
        if (req_type) config_address_next = write_data;
        else cmd.imm = config_address;
      end else if (access_size == 3'd1) begin
        if (req_type) begin
          byte_regs_next[port_offset[1:0]] = (port_offset[1:0] == 2'd0) ?
                                             (write_data[7:0] & 8'hfe) : write_data[7:0];
        end else begin
          cmd.imm = {24'd0, byte_regs[port_offset[1:0]]};
        end
      end else if (!req_type) begin
        cmd.imm = ALL_ONES;
      end
      cmd.do_map = 1'b0;
    end else if (!size_ok) begin
      if (!req_type) cmd.imm = ALL_ONES;
      cmd.do_map = 1'b0;
    end else if (!req_type) begin
      if (here) cmd.kind = CMD_MEM_RD;
      else cmd.imm = ones;
    end else if (config_address[31] && (here || map_hit)) begin
      cmd.kind = CMD_MEM_WR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      config_address <= '0;
      byte_regs[0] <= 8'h00;
      byte_regs[1] <= 8'h00;
      byte_regs[2] <= 8'h00;
      byte_regs[3] <= 8'h80;
    end else if (accept) begin
      config_address <= config_address_next;
      for (int b = 0; b < BANKS; b++) begin
        byte_regs[b] <= byte_regs_next[b];
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/pcsa_queue.sv
// two-entry item queue between front and back
`default_nettype none
module pcsa_queue (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  pcsa_pkg::cmd_t push_cmd,
  input  wire logic      pop,
  output pcsa_pkg::cmd_t pop_cmd,
  output logic           full,
  output logic           empty
);
  import pcsa_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> hdl/pcsa_back.sv
// back end: banked device zero space, masked write-back, map word, results
`default_nettype none
module pcsa_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_empty,
  input  pcsa_pkg::cmd_t   q_cmd,
  output logic             q_pop,
  output logic             done,
  output logic [31:0]      read_data,
  output logic [15:0]      map_word,
  output logic             map_changed
);
  import pcsa_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t     state;
  cmd_t       cur;
  logic [7:0] mem [BANKS][BANK_ROWS];
  logic [7:0] rdata [BANKS];
  logic       vld [SPACE_BYTES];
  logic       vld_q [BANKS];
  logic [5:0] row_q [BANKS];
  logic [1:0] lane_q [BANKS];

  logic [1:0] lane_n [BANKS];
  logic [7:0] pos_n [BANKS];
  logic [7:0] old_b [BANKS];
  logic [7:0] new_b [BANKS];
  logic       wen_b [BANKS];
  logic [7:0] idx_b [BANKS];
  logic [31:0] rd_word;
  logic [15:0] map_word_next;

  assign q_pop = (state == ST_IDLE) && !q_empty;

  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      lane_n[b] = 2'(b) - q_cmd.off[1:0];
      pos_n[b]  = q_cmd.off + {6'd0, lane_n[b]};
      idx_b[b]  = {row_q[b], 2'(b)};
      old_b[b]  = vld_q[b] ? rdata[b] : dev0_init(idx_b[b]);
      new_b[b]  = (old_b[b] & dev0_protect(idx_b[b])) |
                  (cur.wdata[8*lane_q[b] +: 8] & ~dev0_protect(idx_b[b]));
      wen_b[b]  = (state == ST_EXEC) && (cur.kind == CMD_MEM_WR) && cur.here &&
                  ({1'b0, lane_q[b]} < cur.size);
    end
    rd_word = '0;
    for (int i = 0; i < BANKS; i++) begin
      if (3'(i) < cur.size) begin
        rd_word[8*i +: 8] = old_b[2'(cur.off[1:0] + 2'(i))];
      end
    end
    map_word_next = {{4{cur.map_byte[7]}}, cur.map_byte[5], cur.map_byte[4], map_word[9:0]};
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < BANKS; b++) begin
      if (wen_b[b]) mem[b][row_q[b]] <= new_b[b];
      if (q_pop) rdata[b] <= mem[b][pos_n[b][7:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SPACE_BYTES; k++) vld[k] <= 1'b0;
    end else begin
      for (int b = 0; b < BANKS; b++) begin
        if (wen_b[b]) vld[idx_b[b]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
      for (int b = 0; b < BANKS; b++) begin
        row_q[b]  <= pos_n[b][7:2];
        lane_q[b] <= lane_n[b];
        vld_q[b]  <= vld[{pos_n[b][7:2], 2'(b)}];
      end
    end
    if (rst) begin
      state       <= ST_IDLE;
      done        <= 1'b0;
      map_changed <= 1'b0;
      map_word    <= '0;
      read_data   <= '0;
    end else begin
      done        <= 1'b0;
      map_changed <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_pop) state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          case (cur.kind)
            CMD_MEM_RD: read_data <= rd_word;
            CMD_MEM_WR: read_data <= '0;
            default:    read_data <= cur.imm;
          endcase
          if (cur.kind == CMD_MEM_WR && cur.do_map) begin
            map_word    <= map_word_next;
            map_changed <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/pci_config_space_access_top.sv
// top level of the configuration mechanism one host block
`default_nettype none
// Configuration mechanism one host for bus zero. An item is taken when start
// is high and busy low; its result appears for exactly one cycle with done
// high and cannot be held off. In the back end each item first reads the
// banked device zero space (one port per byte bank), then is merged, written
// back and its result driven. Address and byte registers are handled in the
// front end at acceptance; a two-entry queue lets the front keep taking items
// while the back works, so busy rises only when the queue is full. The back
// end takes a new item only when idle. No clearing pass is needed after
// reset: per-byte valid flops stand in for the reset image.
module pci_config_space_access_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type,
  input  wire logic [2:0]  port_offset,
  input  wire logic [2:0]  access_size,
  input  wire logic [31:0] write_data,
  // result channel
  output logic             done,
  output logic [31:0]      read_data,
  output logic [15:0]      map_word,
  output logic             map_changed,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import pcsa_pkg::*;

  localparam logic [2:0] REG_PCI_ENABLE = 3'd0;

  logic pci_enable;
  logic accept;
  cmd_t front_cmd;
  cmd_t q_cmd;
  logic q_full;
  logic q_empty;
  logic q_pop;

  // register port: single enable bit, zero wait states
  assign pready = 1'b1;
  assign prdata = (paddr == REG_PCI_ENABLE) ? {31'd0, pci_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pci_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == REG_PCI_ENABLE) begin
      pci_enable <= pwdata[0];
    end
  end

  // accept whenever the queue has room
  assign busy   = q_full;
  assign accept = start && !busy;

  pcsa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pci_enable  (pci_enable),
    .req_type    (req_type),
    .port_offset (port_offset),
    .access_size (access_size),
    .write_data  (write_data),
    .cmd         (front_cmd)
  );

  pcsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  pcsa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .done        (done),
    .read_data   (read_data),
    .map_word    (map_word),
    .map_changed (map_changed)
  );

endmodule
`default_nettype wire

>>> hdl/pcsa_checker.sv
// port-level checks for the configuration space access block
`default_nettype none
`include "pci_config_space_access_top_assert.svh"
module pcsa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        done,
  input wire logic        map_changed,
  input wire logic [15:0] map_word,
  input wire logic        pready
);

  // a done pulse is never followed at once by another
  `PCSA_ASSERT_NEXT(a_done_spaced, done, !done)
  `PCSA_ASSERT_IMPL(a_map_chg_done, map_changed, done)
  // map word moves only with a result that reports it
  `PCSA_ASSERT_NEXT(a_map_stable, !map_changed, !map_changed || done)
  `PCSA_ASSERT_IMPL(a_map_hold, !$past(map_changed) && !$past(rst), $stable(map_word) || done)
  `PCSA_ASSERT_IMPL(a_pready, 1'b1, pready)

endmodule

bind pci_config_space_access_top pcsa_checker u_pcsa_checker (
  .clk         (clk),
  .rst         (rst),
  .done        (done),
  .map_changed (map_changed),
  .map_word    (map_word),
  .pready      (pready)
);
`default_nettype wire
